// ===== rtl/reply_frame_deframe_check_core_defines.svh =====
// ----------------------------------------------------------------------------
// reply frame deframer assertion macros
// Concurrent assertion wrappers clocked on i_clk, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef REPLY_FRAME_DEFRAME_CHECK_CORE_DEFINES_SVH
`define REPLY_FRAME_DEFRAME_CHECK_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked only while out of reset
`define RFDC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define RFDC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define RFDC_ASSERT(label, prop, msg)
`define RFDC_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== rtl/rfdc_pkg.sv =====
// ----------------------------------------------------------------------------
// rfdc_pkg
// Shared types and codes of the reply frame deframer and checksum checker.
// ----------------------------------------------------------------------------
package rfdc_pkg;

    localparam int MAX_PAYLOAD_DEF = 1024;
    localparam int HEADER_BYTES    = 3;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 16;
    localparam int SUM_W  = 16;

    typedef logic [2:0] t_phase;
    typedef logic [1:0] t_status;

    localparam t_phase PH_HEADER  = 3'd0;
    localparam t_phase PH_PAYLOAD = 3'd1;
    localparam t_phase PH_SUM_LO  = 3'd2;
    localparam t_phase PH_SUM_HI  = 3'd3;
    localparam t_phase PH_IGNORE  = 3'd4;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_MISMATCH  = 2'd1;
    localparam t_status ST_TRUNCATED = 2'd2;
    localparam t_status ST_TOO_LONG  = 2'd3;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

endpackage

// ===== rtl/reply_frame_deframe_check_core.sv =====
// ----------------------------------------------------------------------------
// reply_frame_deframe_check_core: deframes reply bytes, passes payload, checks sum
// result: registered on the output in the cycle after its input beat is accepted
// throughput: one beat per cycle while o_stall is low, set by the frame state update
// reset: synchronous active-low, returns to the header phase with an empty output
// ----------------------------------------------------------------------------
`include "reply_frame_deframe_check_core_defines.svh"

module reply_frame_deframe_check_core
    import rfdc_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input beats
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [BYTE_W-1:0] i_in_byte,
    input  logic              i_chunk_end,
    // result beats
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_out_kind,
    output logic [BYTE_W-1:0] o_payload_byte,
    output logic              o_is_last,
    output t_status           o_frame_status,
    output logic [BYTE_W-1:0] o_protocol_byte,
    output logic [LEN_W-1:0]  o_payload_length,
    output logic [SUM_W-1:0]  o_computed_sum,
    output logic [SUM_W-1:0]  o_received_sum
);

    localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(MAX_PAYLOAD);
    localparam logic [1:0]       HDR_LAST = 2'(HEADER_BYTES - 1);

    // frame state
    t_phase             r_phase, n_phase;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [LEN_W-1:0]   r_count, n_count;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [BYTE_W-1:0]  r_plow, n_plow;
    logic               r_pval, n_pval;
    logic [SUM_W-1:0]   r_trail, n_trail;
    logic [BYTE_W-1:0]  r_ver, n_ver;

    // result register
    logic               r_out_valid;
    logic               r_kind;
    logic [BYTE_W-1:0]  r_pbyte;
    t_status            r_status;
    logic [BYTE_W-1:0]  r_proto;
    logic [LEN_W-1:0]   r_olen;
    logic [SUM_W-1:0]   r_csum;
    logic [SUM_W-1:0]   r_rsum;

    logic               accept;
    logic               emit;
    logic               e_kind;
    t_status            e_status;
    logic [BYTE_W-1:0]  e_byte;
    logic [BYTE_W-1:0]  e_ver;
    logic [LEN_W-1:0]   e_len;
    logic [SUM_W-1:0]   e_sum;
    logic [SUM_W-1:0]   e_trail;
    logic               clr;

    logic [SUM_W-1:0]   pair_sum;
    logic [SUM_W-1:0]   fed_sum;
    logic               fed_pval;
    logic [BYTE_W-1:0]  fed_plow;
    logic [SUM_W-1:0]   closed_sum;
    logic [LEN_W-1:0]   hdr_len;
    logic [LEN_W-1:0]   cnt_inc;

    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        pair_sum   = r_sum - {i_in_byte, r_plow};
        fed_sum    = r_pval ? pair_sum : r_sum;
        fed_pval   = !r_pval;
        fed_plow   = r_pval ? r_plow : i_in_byte;
        // odd trailing byte goes in as the high half
        closed_sum = r_pval ? pair_sum : (r_sum - {i_in_byte, 8'h00});
        hdr_len    = {i_in_byte, r_len[7:0]};
        cnt_inc    = r_count + 1'b1;

        n_phase  = r_phase;
        n_len    = r_len;
        n_count  = r_count;
        n_sum    = r_sum;
        n_plow   = r_plow;
        n_pval   = r_pval;
        n_trail  = r_trail;
        n_ver    = r_ver;
        emit     = 1'b0;
        e_kind   = KIND_STATUS;
        e_status = ST_OK;
        e_byte   = '0;
        clr      = 1'b0;

        case (r_phase)
            PH_HEADER: begin
                n_sum  = fed_sum;
                n_pval = fed_pval;
                n_plow = fed_plow;
                if (r_count[1:0] == HDR_LAST) begin
                    n_len   = hdr_len;
                    n_count = '0;
                    if (hdr_len > MAX_LEN) begin
                        emit     = 1'b1;
                        e_status = ST_TOO_LONG;
                        n_phase  = PH_IGNORE;
                        clr      = i_chunk_end;
                    end else begin
                        if (hdr_len == '0) begin
                            n_sum   = closed_sum;
                            n_pval  = 1'b0;
                            n_phase = PH_SUM_LO;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                        if (i_chunk_end) begin
                            emit     = 1'b1;
                            e_status = ST_TRUNCATED;
                            clr      = 1'b1;
                        end
                    end
                end else begin
                    if (r_count[1:0] == 2'd0) begin
                        n_ver = i_in_byte;
                    end else begin
                        n_len = {{(LEN_W-BYTE_W){1'b0}}, i_in_byte};
                    end
                    n_count = cnt_inc;
                    if (i_chunk_end) begin
                        emit     = 1'b1;
                        e_status = ST_TRUNCATED;
                        clr      = 1'b1;
                    end
                end
            end
            PH_PAYLOAD: begin
                n_sum   = fed_sum;
                n_pval  = fed_pval;
                n_plow  = fed_plow;
                n_count = cnt_inc;
                if (cnt_inc >= r_len) begin
                    n_sum   = closed_sum;
                    n_pval  = 1'b0;
                    n_phase = PH_SUM_LO;
                end
                emit = 1'b1;
                if (i_chunk_end) begin
                    e_status = ST_TRUNCATED;
                    clr      = 1'b1;
                end else begin
                    e_kind = KIND_PAYLOAD;
                    e_byte = i_in_byte;
                end
            end
            PH_SUM_LO: begin
                n_trail = {{(SUM_W-BYTE_W){1'b0}}, i_in_byte};
                n_phase = PH_SUM_HI;
                if (i_chunk_end) begin
                    emit     = 1'b1;
                    e_status = ST_TRUNCATED;
                    clr      = 1'b1;
                end
            end
            PH_SUM_HI: begin
                n_trail  = {i_in_byte, r_trail[7:0]};
                emit     = 1'b1;
                e_status = (n_trail == r_sum) ? ST_OK : ST_MISMATCH;
                n_phase  = PH_IGNORE;
                clr      = i_chunk_end;
            end
            default: begin
                clr = i_chunk_end;
            end
        endcase

        // result fields see the state before a rearm
        e_ver   = n_ver;
        e_len   = n_len;
        e_sum   = n_sum;
        e_trail = n_trail;

        if (clr) begin
            n_phase = PH_HEADER;
            n_len   = '0;
            n_count = '0;
            n_sum   = '0;
            n_plow  = '0;
            n_pval  = 1'b0;
            n_trail = '0;
            n_ver   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_len   <= '0;
            r_count <= '0;
            r_sum   <= '0;
            r_plow  <= '0;
            r_pval  <= 1'b0;
            r_trail <= '0;
            r_ver   <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_count <= n_count;
            r_sum   <= n_sum;
            r_plow  <= n_plow;
            r_pval  <= n_pval;
            r_trail <= n_trail;
            r_ver   <= n_ver;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= emit;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_kind   <= e_kind;
            r_pbyte  <= e_byte;
            r_status <= (e_kind == KIND_STATUS) ? e_status : ST_OK;
            r_proto  <= e_ver;
            r_olen   <= e_len;
            r_csum   <= (e_kind == KIND_STATUS) ? e_sum : '0;
            r_rsum   <= (e_kind == KIND_STATUS) ? e_trail : '0;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_out_kind       = r_kind;
    assign o_payload_byte   = r_pbyte;
    assign o_is_last        = r_kind;
    assign o_frame_status   = r_status;
    assign o_protocol_byte  = r_proto;
    assign o_payload_length = r_olen;
    assign o_computed_sum   = r_csum;
    assign o_received_sum   = r_rsum;

    `RFDC_ASSERT(a_sum_closed, (r_phase == PH_SUM_LO || r_phase == PH_SUM_HI) |-> !r_pval, "odd byte left open in trailer phase")
    `RFDC_ASSERT(a_count_in_len, (r_phase == PH_PAYLOAD) |-> (r_count < r_len), "payload count reached declared length")
    `RFDC_ASSERT(a_hdr_index, (r_phase == PH_HEADER) |-> (r_count < LEN_W'(HEADER_BYTES)), "header index out of range")
    `RFDC_ASSERT(a_status_zero_byte, (o_valid && o_out_kind) |-> (o_payload_byte == '0), "status beat carries payload byte")
    `RFDC_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_valid, "result valid after reset")

endmodule

// ===== bench/reply_frame_deframe_check_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reply_frame_deframe_check_core_tb
// Feeds framed reply byte streams (good, corrupted, cut short, oversized and
// noise) through the deframer and checks every payload and status beat
// against a cycle-free model of the frame parser.
// ----------------------------------------------------------------------------
module reply_frame_deframe_check_core_tb;
    import rfdc_pkg::*;

    localparam int MAX_LEN    = MAX_PAYLOAD_DEF;
    localparam int CYCLE_MAX  = 400000;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } rx_beat_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] pbyte;
        logic       last;
        t_status    status;
        logic [7:0] proto;
        logic [15:0] len;
        logic [15:0] csum;
        logic [15:0] rsum;
    } reply_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_in_byte = 8'h00;
    logic        i_chunk_end = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_out_kind;
    logic [7:0]  o_payload_byte;
    logic        o_is_last;
    t_status     o_frame_status;
    logic [7:0]  o_protocol_byte;
    logic [15:0] o_payload_length;
    logic [15:0] o_computed_sum;
    logic [15:0] o_received_sum;

    reply_frame_deframe_check_core #(
        .MAX_PAYLOAD(MAX_LEN)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_in_byte        (i_in_byte),
        .i_chunk_end      (i_chunk_end),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_out_kind       (o_out_kind),
        .o_payload_byte   (o_payload_byte),
        .o_is_last        (o_is_last),
        .o_frame_status   (o_frame_status),
        .o_protocol_byte  (o_protocol_byte),
        .o_payload_length (o_payload_length),
        .o_computed_sum   (o_computed_sum),
        .o_received_sum   (o_received_sum)
    );

    rx_beat_t rx_beat_q[$];
    reply_t   reply_q[$];
    int       pushed_cnt = 0;
    int       accepted_cnt = 0;
    int       mismatch_cnt = 0;
    int       cycle_cnt = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       hold_token = 0;
    int       hold_seen = 0;
    int       hold_left = 0;

    // frame parser model state
    t_phase      fr_phase;
    logic [15:0] fr_len;
    logic [15:0] fr_seen;
    logic [15:0] fr_acc;
    logic [7:0]  fr_lo;
    logic        fr_lo_valid;
    logic [15:0] fr_trail;
    logic [7:0]  fr_ver;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic void restart_frame();
        fr_phase    = PH_HEADER;
        fr_len      = '0;
        fr_seen     = '0;
        fr_acc      = '0;
        fr_lo       = '0;
        fr_lo_valid = 1'b0;
        fr_trail    = '0;
        fr_ver      = '0;
    endfunction

    // bytes pair up as little-endian words subtracted from the running sum
    function automatic void add_to_sum(input logic [7:0] b);
        if (fr_lo_valid) begin
            fr_acc      = fr_acc - {b, fr_lo};
            fr_lo_valid = 1'b0;
        end else begin
            fr_lo       = b;
            fr_lo_valid = 1'b1;
        end
    endfunction

    function automatic void flush_odd();
        if (fr_lo_valid) begin
            fr_acc      = fr_acc - {fr_lo, 8'h00};
            fr_lo_valid = 1'b0;
        end
    endfunction

    function automatic void frame_done(input logic last);
        if (last) restart_frame();
        else fr_phase = PH_IGNORE;
    endfunction

    function automatic reply_t make_reply(input logic kind, input logic [7:0] pbyte,
                                          input t_status status);
        reply_t r;
        r.kind   = kind;
        r.pbyte  = pbyte;
        r.last   = kind;
        r.status = status;
        r.proto  = fr_ver;
        r.len    = fr_len;
        r.csum   = kind ? fr_acc : 16'h0000;
        r.rsum   = kind ? fr_trail : 16'h0000;
        return r;
    endfunction

    task automatic predict_reply(input logic [7:0] b, input logic last);
        bit too_long;
        too_long = 1'b0;
        case (fr_phase)
            PH_HEADER: begin
                if (fr_seen == 0) fr_ver = b;
                else if (fr_seen == 1) fr_len = {8'h00, b};
                else fr_len = {b, fr_len[7:0]};
                add_to_sum(b);
                fr_seen = fr_seen + 16'd1;
                if (fr_seen >= HEADER_BYTES) begin
                    fr_seen  = '0;
                    too_long = (fr_len > MAX_LEN);
                    if (!too_long) begin
                        if (fr_len == 0) begin
                            flush_odd();
                            fr_phase = PH_SUM_LO;
                        end else begin
                            fr_phase = PH_PAYLOAD;
                        end
                    end
                end
                if (too_long) begin
                    reply_q.push_back(make_reply(KIND_STATUS, 8'h00, ST_TOO_LONG));
                    frame_done(last);
                end else if (last) begin
                    reply_q.push_back(make_reply(KIND_STATUS, 8'h00, ST_TRUNCATED));
                    restart_frame();
                end
            end
            PH_PAYLOAD: begin
                add_to_sum(b);
                fr_seen = fr_seen + 16'd1;
                if (fr_seen >= fr_len) begin
                    flush_odd();
                    fr_phase = PH_SUM_LO;
                end
                // a chunk end swallows the payload beat and reports truncation
                if (last) begin
                    reply_q.push_back(make_reply(KIND_STATUS, 8'h00, ST_TRUNCATED));
                    restart_frame();
                end else begin
                    reply_q.push_back(make_reply(KIND_PAYLOAD, b, ST_OK));
                end
            end
            PH_SUM_LO: begin
                fr_trail = {8'h00, b};
                fr_phase = PH_SUM_HI;
                if (last) begin
                    reply_q.push_back(make_reply(KIND_STATUS, 8'h00, ST_TRUNCATED));
                    restart_frame();
                end
            end
            PH_SUM_HI: begin
                fr_trail = {b, fr_trail[7:0]};
                reply_q.push_back(make_reply(KIND_STATUS, 8'h00,
                                             (fr_trail == fr_acc) ? ST_OK : ST_MISMATCH));
                frame_done(last);
            end
            default: begin
                if (last) restart_frame();
            end
        endcase
    endtask

    task automatic queue_beat(input logic [7:0] data, input logic last);
        rx_beat_t bt;
        bt.data = data;
        bt.last = last;
        rx_beat_q.push_back(bt);
        pushed_cnt++;
    endtask

    // builds one frame; cut >= 0 ends the chunk on that byte, tail adds
    // trailing junk that ends the chunk instead of the last frame byte
    task automatic queue_frame(input logic [7:0] ver, input logic [15:0] len,
                               input bit good_sum, input int cut, input int tail);
        logic [7:0]  fb[$];
        logic [15:0] sum;
        bit          trunc;
        int          n;
        fb.push_back(ver);
        fb.push_back(len[7:0]);
        fb.push_back(len[15:8]);
        if (len <= MAX_LEN) begin
            repeat (len) fb.push_back(8'($urandom));
            sum = 16'h0000;
            for (int i = 0; i < fb.size(); i += 2) begin
                sum -= (i + 1 < fb.size()) ? {fb[i+1], fb[i]} : {fb[i], 8'h00};
            end
            if (!good_sum) sum ^= 16'($urandom_range(16'hFFFF, 1));
            fb.push_back(sum[7:0]);
            fb.push_back(sum[15:8]);
        end
        trunc = (cut >= 0 && cut < fb.size());
        n = trunc ? cut + 1 : fb.size();
        for (int i = 0; i < n; i++) begin
            queue_beat(fb[i], (i == n - 1) && (trunc || tail == 0));
        end
        if (!trunc) begin
            for (int k = 0; k < tail; k++) queue_beat(8'($urandom), k == tail - 1);
        end
    endtask

    task automatic queue_random_frames(input int budget);
        int          start;
        int          pick;
        logic [15:0] len;
        start = pushed_cnt;
        while (pushed_cnt - start < budget) begin
            pick = $urandom_range(99);
            len  = ($urandom_range(99) < 85) ? 16'($urandom_range(16)) :
                                               16'($urandom_range(80, 17));
            if (pick < 60) begin
                queue_frame(8'($urandom), len, $urandom_range(99) < 75, -1,
                            ($urandom_range(99) < 70) ? 0 : $urandom_range(4, 1));
            end else if (pick < 75) begin
                queue_frame(8'($urandom), len, 1'b1, $urandom_range(len + 4), 0);
            end else if (pick < 87) begin
                case ($urandom_range(2))
                    0: len = 16'(MAX_LEN + 1);
                    1: len = 16'hFFFF;
                    default: len = 16'($urandom_range(16'hFFFF, MAX_LEN + 1));
                endcase
                queue_frame(8'($urandom), len, 1'b1, -1, $urandom_range(3));
            end else begin
                // line noise, mostly closed by a chunk end
                repeat ($urandom_range(5)) queue_beat(8'($urandom), $urandom_range(99) < 20);
                queue_beat(8'($urandom), $urandom_range(99) < 80);
            end
        end
    endtask

    task automatic drain_replies();
        while (accepted_cnt != pushed_cnt || reply_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // input driver
    always @(posedge i_clk) begin
        rx_beat_t bt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && o_stall)) begin
            if (i_valid) begin
                predict_reply(i_in_byte, i_chunk_end);
                accepted_cnt++;
            end
            if (rx_beat_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                bt = rx_beat_q.pop_front();
                i_valid     <= 1'b1;
                i_in_byte   <= bt.data;
                i_chunk_end <= bt.last;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver back-pressure, with one long hold-off at the start of the first phase
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_seen != hold_token) begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        reply_t got;
        reply_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_out_kind, o_payload_byte, o_is_last, o_frame_status, o_protocol_byte,
                   o_payload_length, o_computed_sum, o_received_sum};
            if (reply_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected beat: kind=%0d byte=%h last=%0d st=%0d ver=%h",
                             got.kind, got.pbyte, got.last, got.status, got.proto,
                             " len=%0d csum=%h rsum=%h", got.len, got.csum, got.rsum);
            end else begin
                want = reply_q.pop_front();
                if (got !== want) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("mismatch exp: kind=%0d byte=%h last=%0d st=%0d ver=%h",
                                 want.kind, want.pbyte, want.last, want.status, want.proto,
                                 " len=%0d csum=%h rsum=%h", want.len, want.csum,
                                 want.rsum);
                        $display("         act: kind=%0d byte=%h last=%0d st=%0d ver=%h",
                                 got.kind, got.pbyte, got.last, got.status, got.proto,
                                 " len=%0d csum=%h rsum=%h", got.len, got.csum,
                                 got.rsum);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_MAX) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int idle_tab[4];
        int stall_tab[4];
        idle_tab  = '{0, 75, 0, 17};
        stall_tab = '{0, 0, 75, 17};
        restart_frame();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = idle_tab[p];
            recv_stall_pct = stall_tab[p];
            if (p == 0) begin
                hold_token++;
                // empty payload with junk after the frame, odd payload,
                // bad checksum, oversized length, chunk cut inside header
                queue_frame(8'hFF, 16'd0, 1'b1, -1, 1);
                queue_frame(8'h00, 16'd1, 1'b1, -1, 0);
                queue_frame(8'hA5, 16'd2, 1'b0, -1, 0);
                queue_frame(8'h5A, 16'hFFFF, 1'b1, -1, 0);
                queue_frame(8'h3C, 16'd4, 1'b1, 1, 0);
            end
            // longest legal length is taken as payload, cut short early
            if (p == 3) queue_frame(8'($urandom), 16'(MAX_LEN), 1'b1, 40, 0);
            queue_random_frames(250);
            // sender stays quiet until every reply of the phase is back
            drain_replies();
        end
        if (mismatch_cnt == 0 && reply_q.size() == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

endmodule
